FILE: design/mtrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtrs_pkg;

  localparam int BLOCK_EDGE     = 8;
  localparam int MAX_MCU_BLOCKS = 4;
  localparam int EDGE_SHIFT     = $clog2(BLOCK_EDGE);
  localparam int QUEUE_DEPTH    = 4;
  localparam int REM_W          = 32;
  localparam int REM_DIV_W      = 16;
  localparam int RECIP3         = 171;
  localparam int RECIP3_SHIFT   = 9;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_STRIP_ROWS   = 2'd2,
    REG_DATA_BASE    = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MUL,
    ST_STRIP,
    ST_SMUL,
    ST_REMH,
    ST_REMP,
    ST_FIN
  } place_state_t;

  typedef struct packed {
    logic        first;
    logic [2:0]  bh;
    logic [2:0]  bv;
    logic [4:0]  row;
    logic [5:0]  col;
    logic [23:0] rgb;
  } pix_t;

  typedef struct packed {
    logic [13:0] height;
    logic [13:0] strip_rows;
    logic [15:0] row_bytes;
    logic [31:0] data_base;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [REM_W-1:0]     dividend;
    logic [REM_DIV_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic                 done;
    logic [REM_DIV_W-1:0] rem;
  } rem_rsp_t;

  function automatic logic [2:0] clamp_blocks(input logic [2:0] v);
    logic [2:0] r;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (v > 3'(MAX_MCU_BLOCKS)) begin
      r = 3'(MAX_MCU_BLOCKS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [5:0] blk_px(input logic [2:0] b);
    logic [5:0] r;
    r = {3'b000, b} << EDGE_SHIFT;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/mtrs_rem.sv
`timescale 1ns / 1ps
`default_nettype none

module mtrs_rem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mtrs_pkg::rem_req_t req,
  output mtrs_pkg::rem_rsp_t     rsp
);
  import mtrs_pkg::*;

  localparam int CNT_W = $clog2(REM_W);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [REM_W-1:0]     dvd_r;
  logic [REM_DIV_W-1:0] dvs_r;
  logic [REM_DIV_W-1:0] rem_r;
  logic [REM_DIV_W:0]   trial;
  logic [REM_DIV_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[REM_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = REM_DIV_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[REM_DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(REM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[REM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

FILE: design/mtrs_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mtrs_queue #(
  parameter int DEPTH = mtrs_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mtrs_pkg::pix_t wr_data,
  input  wire logic          pop,
  output mtrs_pkg::pix_t     rd_data,
  output logic               not_empty,
  output logic               full
);
  import mtrs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pix_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data   = slots_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));

endmodule

`default_nettype wire

FILE: design/mtrs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mtrs_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_blocks_h,
  input  wire logic [2:0]  in_blocks_v,
  input  wire logic [23:0] in_pixel_rgb,
  input  wire logic        q_full,
  output logic             push,
  output mtrs_pkg::pix_t   entry
);
  import mtrs_pkg::*;

  logic [4:0] pixel_row_r;
  logic [5:0] pixel_col_r;
  logic [4:0] pixel_row_nxt;
  logic [5:0] pixel_col_nxt;
  logic [2:0] bh;
  logic [2:0] bv;
  logic [6:0] col_p1;
  logic [5:0] row_p1;

  assign bh       = clamp_blocks(in_blocks_h);
  assign bv       = clamp_blocks(in_blocks_v);
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    col_p1        = {1'b0, pixel_col_r} + 7'd1;
    row_p1        = {1'b0, pixel_row_r} + 6'd1;
    pixel_col_nxt = col_p1[5:0];
    pixel_row_nxt = pixel_row_r;
    if (col_p1 >= {1'b0, blk_px(bh)}) begin
      pixel_col_nxt = '0;
      pixel_row_nxt = (row_p1 >= blk_px(bv)) ? 5'd0 : row_p1[4:0];
    end
  end

  always_comb begin
    entry.first = (pixel_row_r == '0) && (pixel_col_r == '0);
    entry.bh    = bh;
    entry.bv    = bv;
    entry.row   = pixel_row_r;
    entry.col   = pixel_col_r;
    entry.rgb   = in_pixel_rgb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_row_r <= '0;
      pixel_col_r <= '0;
    end else if (push) begin
      pixel_row_r <= pixel_row_nxt;
      pixel_col_r <= pixel_col_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/mtrs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mtrs_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mtrs_pkg::cfg_t cfg,
  input  wire mtrs_pkg::pix_t head,
  input  wire logic           head_valid,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [31:0]         out_byte_address,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue
);
  import mtrs_pkg::*;

  place_state_t state_r;
  place_state_t state_nxt;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  logic [12:0] strip_index_r;
  logic [31:0] mcu_position_r;
  logic [31:0] mcu_start_r;
  logic [5:0]  kept_cols_r;
  logic [5:0]  kept_rows_r;
  logic        placed_r;

  logic [27:0] t1_r;
  logic [27:0] t2_r;
  logic [29:0] sbytes_r;
  logic [21:0] down_r;
  logic        last_r;
  logic [31:0] prod_r;
  logic [13:0] hrem_r;
  logic [15:0] used_r;

  logic        out_valid_r;
  logic [31:0] out_addr_r;
  logic [23:0] out_rgb_r;

  logic [12:0] si_inc;
  logic [27:0] t1_nxt;
  logic [27:0] t2_nxt;
  logic [29:0] sbytes_nxt;
  logic [21:0] down_nxt;
  logic [5:0]  bv_m1;
  logic [32:0] reach;
  logic [27:0] height_w;
  logic        advance;
  logic [31:0] prod_nxt;

  logic [6:0]  span;
  logic        clip;
  logic [15:0] room;
  logic [14:0] room_q;
  logic [5:0]  cols;
  logic [7:0]  cols3;
  logic [31:0] pos_nxt;
  logic [31:0] start_nxt;
  logic [13:0] last_h;
  logic [13:0] rows_max;
  logic [5:0]  rows_px;
  logic [5:0]  rows;

  logic        keep;
  logic [20:0] row_off;
  logic [7:0]  col3;
  logic [31:0] addr_nxt;

  mtrs_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  always_comb begin
    si_inc     = strip_index_r + 13'd1;
    t1_nxt     = {14'd0, {1'b0, strip_index_r} + 14'd1} * {14'd0, cfg.strip_rows};
    t2_nxt     = {14'd0, {1'b0, si_inc} + 14'd1} * {14'd0, cfg.strip_rows};
    sbytes_nxt = {16'd0, cfg.strip_rows} * {14'd0, cfg.row_bytes};
    bv_m1      = blk_px(head.bv) - 6'd1;
    down_nxt   = {16'd0, bv_m1} * {6'd0, cfg.row_bytes};
    height_w   = {14'd0, cfg.height};
    reach      = {1'b0, mcu_position_r} + {11'd0, down_r};
    advance    = (t1_r < height_w) && (reach >= {3'd0, sbytes_r});
    prod_nxt   = {19'd0, strip_index_r} * {2'd0, sbytes_r};
  end

  always_comb begin
    span      = {head.bh, 4'b0000} + {1'b0, head.bh, 3'b000};
    clip      = ({1'b0, used_r} + {10'd0, span}) > {1'b0, cfg.row_bytes};
    room      = cfg.row_bytes - used_r;
    room_q    = {8'd0, room[6:0]} * 15'(RECIP3);
    cols      = clip ? room_q[RECIP3_SHIFT+5:RECIP3_SHIFT] : blk_px(head.bh);
    cols3     = {1'b0, cols, 1'b0} + {2'b00, cols};
    pos_nxt   = mcu_position_r + (clip ? {10'd0, down_r} : 32'd0) + {24'd0, cols3};
    start_nxt = cfg.data_base + prod_r + mcu_position_r;
    last_h    = (hrem_r == '0) ? cfg.strip_rows : hrem_r;
    rows_max  = last_r ? last_h : cfg.strip_rows;
    rows_px   = blk_px(head.bv);
    rows      = ({8'd0, rows_px} > rows_max) ? rows_max[5:0] : rows_px;
  end

  always_comb begin
    keep     = ({1'b0, head.row} < kept_rows_r) && (head.col < kept_cols_r);
    row_off  = {16'd0, head.row} * {5'd0, cfg.row_bytes};
    col3     = {1'b0, head.col, 1'b0} + {2'b00, head.col};
    addr_nxt = mcu_start_r + {11'd0, row_off} + {24'd0, col3};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (head_valid && head.first && !placed_r) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_STRIP;
      ST_STRIP: state_nxt = ST_SMUL;
      ST_SMUL:  state_nxt = ST_REMH;
      ST_REMH: begin
        if (rem_rsp.done) begin
          state_nxt = ST_REMP;
        end
      end
      ST_REMP: begin
        if (rem_rsp.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    pop              = 1'b0;
    rem_req.start    = 1'b0;
    rem_req.dividend = mcu_position_r;
    rem_req.divisor  = cfg.row_bytes;
    unique case (state_r)
      ST_RUN: begin
        pop = head_valid && (!head.first || placed_r) && (!out_valid_r || !out_stall);
      end
      ST_SMUL: begin
        rem_req.start    = 1'b1;
        rem_req.dividend = {18'd0, cfg.height};
        rem_req.divisor  = {2'd0, cfg.strip_rows};
      end
      ST_REMH: begin
        rem_req.start = rem_rsp.done;
      end
      ST_MUL, ST_STRIP, ST_REMP, ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_RUN;
      strip_index_r  <= '0;
      mcu_position_r <= '0;
      mcu_start_r    <= '0;
      kept_cols_r    <= '0;
      kept_rows_r    <= '0;
      placed_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_STRIP && advance) begin
        strip_index_r  <= si_inc;
        mcu_position_r <= '0;
      end
      if (state_r == ST_FIN) begin
        mcu_position_r <= pos_nxt;
        mcu_start_r    <= start_nxt;
        kept_cols_r    <= cols;
        kept_rows_r    <= rows;
        placed_r       <= 1'b1;
      end
      if (pop) begin
        placed_r    <= 1'b0;
        out_valid_r <= keep;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      t1_r     <= t1_nxt;
      t2_r     <= t2_nxt;
      sbytes_r <= sbytes_nxt;
      down_r   <= down_nxt;
    end
    if (state_r == ST_STRIP) begin
      last_r <= advance ? (t2_r >= height_w) : (t1_r >= height_w);
    end
    if (state_r == ST_SMUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_REMH && rem_rsp.done) begin
      hrem_r <= rem_rsp.rem[13:0];
    end
    if (state_r == ST_REMP && rem_rsp.done) begin
      used_r <= rem_rsp.rem;
    end
    if (pop && keep) begin
      out_addr_r <= addr_nxt;
      out_rgb_r  <= head.rgb;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_address = out_addr_r;
  assign out_red          = out_rgb_r[23:16];
  assign out_green        = out_rgb_r[15:8];
  assign out_blue         = out_rgb_r[7:0];

  a_place_sets_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (placed_r && (kept_rows_r != '0)))
    else $error("placement finished without a kept row");

  a_placed_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
    placed_r |-> (head_valid && head.first))
    else $error("placement flag set without a first pixel at the queue head");

  a_kept_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (kept_cols_r <= 6'(BLOCK_EDGE * MAX_MCU_BLOCKS)) &&
    (kept_rows_r <= 6'(BLOCK_EDGE * MAX_MCU_BLOCKS)))
    else $error("kept size exceeds the largest MCU");

endmodule

`default_nettype wire

FILE: design/mcu_to_raster_strip_writer.sv
// An ordinary pixel is pushed into the queue and, when popped from its head, registered
// at the output. The first pixel of an MCU waits at the queue head while its placement
// is worked out once per MCU, through the two 32-step remainder runs of the shared
// bit-serial remainder unit. Otherwise one pixel per cycle while out_stall is low.
// Reset (synchronous, active low) empties the queue, zeroes the counters and the kept
// placement results, and loads width 1, height 1, strip rows 8 and data base 0.
`timescale 1ns / 1ps
`default_nettype none

module mcu_to_raster_strip_writer #(
  parameter int QUEUE_DEPTH = mtrs_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_blocks_h,
  input  wire logic [2:0]  in_blocks_v,
  input  wire logic [23:0] in_pixel_rgb,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_byte_address,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue
);
  import mtrs_pkg::*;

  logic [13:0] img_width_r;
  logic [13:0] image_height_r;
  logic [13:0] strip_rows_r;
  logic [31:0] data_base_r;
  logic [13:0] width_1;
  cfg_t        cfg;

  pix_t entry;
  pix_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r    <= 14'd1;
      image_height_r <= 14'd1;
      strip_rows_r   <= 14'd8;
      data_base_r    <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_IMAGE_WIDTH:  img_width_r    <= cfg_data[13:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[13:0];
        REG_STRIP_ROWS:   strip_rows_r   <= cfg_data[13:0];
        REG_DATA_BASE:    data_base_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    width_1        = (img_width_r == '0) ? 14'd1 : img_width_r;
    cfg.height     = (image_height_r == '0) ? 14'd1 : image_height_r;
    cfg.strip_rows = (strip_rows_r == '0) ? 14'd1 : strip_rows_r;
    cfg.row_bytes  = {1'b0, width_1, 1'b0} + {2'b00, width_1};
    cfg.data_base  = data_base_r;
  end

  mtrs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_blocks_h  (in_blocks_h),
    .in_blocks_v  (in_blocks_v),
    .in_pixel_rgb (in_pixel_rgb),
    .q_full       (q_full),
    .push         (push),
    .entry        (entry)
  );

  mtrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (entry),
    .pop       (pop),
    .rd_data   (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  mtrs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head             (head),
    .head_valid       (q_not_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_address (out_byte_address),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue)
  );

endmodule

`default_nettype wire
